// ===== design/mf5_pkg.sv =====
`timescale 1ns / 1ps
package mf5_pkg;
	localparam int MAX_WIDTH = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int PIX_W = 8;
	localparam int WIN_SIDE = 5;
	localparam int WIN_SIZE = 25;
	localparam int MEDIAN_RANK = 12;
	localparam int HIST_LINES = 4;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = 12;
	localparam int CFG_W_W = 11;
	localparam int CFG_H_W = 13;
	localparam int CFG_DATA_W = 16;
	localparam int COLUMN_W = HIST_LINES * PIX_W;
	localparam int SORT_STAGES = WIN_SIZE;

	localparam logic CFG_IDX_WIDTH = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic last;
		logic emit;
	} mf5_tag_t;
endpackage

// ===== design/mf5_ram.sv =====
`timescale 1ns / 1ps
module mf5_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== design/mf5_sort_cell.sv =====
`timescale 1ns / 1ps
module mf5_sort_cell import mf5_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [PIX_W-1:0] in_vals [WIN_SIZE],
	input  logic [WIN_SIZE-1:0] in_done,
	input  mf5_tag_t in_tag,
	input  logic in_valid,
	output logic [PIX_W-1:0] out_vals [WIN_SIZE],
	output logic [WIN_SIZE-1:0] out_done,
	output logic [PIX_W-1:0] out_sel,
	output mf5_tag_t out_tag,
	output logic out_valid
);
	// selection step: rank every element, mark the next smallest as placed
	logic [WIN_SIZE-1:0] is_min;
	logic [WIN_SIZE-1:0] pick;
	logic [PIX_W-1:0] pick_val;
	logic [PIX_W-1:0] vals_q [WIN_SIZE];
	logic [WIN_SIZE-1:0] done_q;
	logic [PIX_W-1:0] sel_q;
	mf5_tag_t tag_q;
	logic valid_q;

	always_comb begin
		for (int i = 0; i < WIN_SIZE; i++) begin
			is_min[i] = !in_done[i];
			for (int j = 0; j < WIN_SIZE; j++) begin
				if (!in_done[j] && j != i) begin
					if (in_vals[j] < in_vals[i] || (in_vals[j] == in_vals[i] && j < i)) begin
						is_min[i] = 1'b0;
					end
				end
			end
		end
		pick = is_min;
		pick_val = '0;
		for (int i = 0; i < WIN_SIZE; i++) begin
			if (pick[i]) begin
				pick_val = in_vals[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vals_q <= in_vals;
			done_q <= in_done | pick;
			sel_q <= pick_val;
			tag_q <= in_tag;
		end
	end

	assign out_vals = vals_q;
	assign out_done = done_q;
	assign out_sel = sel_q;
	assign out_tag = tag_q;
	assign out_valid = valid_q;
endmodule

// ===== design/mf5_median.sv =====
`timescale 1ns / 1ps
module mf5_median import mf5_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [PIX_W-1:0] win [WIN_SIZE],
	input  mf5_tag_t in_tag,
	input  logic in_valid,
	output logic [PIX_W-1:0] median,
	output mf5_tag_t out_tag,
	output logic out_valid
);
	localparam int NC = MEDIAN_RANK + 1;

	logic [PIX_W-1:0] v [NC+1][WIN_SIZE];
	logic [WIN_SIZE-1:0] d [NC+1];
	logic [PIX_W-1:0] sel [NC];
	mf5_tag_t t [NC+1];
	logic vl [NC+1];

	assign v[0] = win;
	assign d[0] = '0;
	assign t[0] = in_tag;
	assign vl[0] = in_valid;

	for (genvar k = 0; k < NC; k++) begin : g_cell
		mf5_sort_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_vals(v[k]), .in_done(d[k]), .in_tag(t[k]), .in_valid(vl[k]),
			.out_vals(v[k+1]), .out_done(d[k+1]), .out_sel(sel[k]), .out_tag(t[k+1]),
			.out_valid(vl[k+1])
		);
	end

	// median is the element placed by the last cell
	assign median = sel[NC-1];
	assign out_tag = t[NC];
	assign out_valid = vl[NC];
endmodule

// ===== design/median_filter_5x5_top.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// s_axis    in   tvalid / tready    tdata: pixel_value
// m_axis    out  tvalid / tready    tdata: median_value, centre_row, centre_col; tlast: frame_last
// cfg       in   cfg_valid / ready  cfg_index, cfg_data
// one pixel per clock unless the output stalls; passes the s1 stage, window and rank cells
// the line store is one memory port pair, read and written once per pixel
// a stalled output freezes the whole pipe; s_axis_tready follows m_axis_tready combinationally
// reset clears counters, window and valid bits; line store contents start undefined
module median_filter_5x5_top import mf5_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] pixel_value
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // [7:0] median_value, [19:8] centre_row, [29:20] centre_col
	output logic m_axis_tlast,        // frame_last
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	logic [CFG_W_W-1:0] width_q;
	logic [CFG_H_W-1:0] height_q;
	logic [COL_W:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W:0] eff_w;
	logic [CFG_H_W-1:0] eff_h;
	logic line_end, frame_end;
	logic en, in_xfer;
	logic [PIX_W-1:0] pix_s1;
	logic valid_s1;
	mf5_tag_t tag_s1;
	logic [COL_W-1:0] col_s1;
	logic [COLUMN_W-1:0] rd_col;
	logic [COLUMN_W-1:0] hold_q;
	logic hold_v_q;
	logic [COLUMN_W-1:0] col_data;
	logic [PIX_W-1:0] win_q [WIN_SIZE];
	logic win_valid_q;
	mf5_tag_t win_tag_q;
	logic [PIX_W-1:0] med;
	mf5_tag_t med_tag;
	logic med_valid;
	logic wr_en_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_W_W'(640);
			height_q <= CFG_H_W'(480);
		end else if (cfg_valid) begin
			if (cfg_index == CFG_IDX_WIDTH) begin
				width_q <= cfg_data[CFG_W_W-1:0];
			end else begin
				height_q <= cfg_data[CFG_H_W-1:0];
			end
		end
	end

	always_comb begin
		if (width_q < CFG_W_W'(5)) begin
			eff_w = (COL_W+1)'(5);
		end else if ({1'b0, width_q} > 12'(MAX_WIDTH)) begin
			eff_w = (COL_W+1)'(MAX_WIDTH);
		end else begin
			eff_w = (COL_W+1)'(width_q);
		end
		if (height_q < CFG_H_W'(5)) begin
			eff_h = CFG_H_W'(5);
		end else if (height_q > CFG_H_W'(MAX_HEIGHT)) begin
			eff_h = CFG_H_W'(MAX_HEIGHT);
		end else begin
			eff_h = height_q;
		end
	end

	// the pipe advances unless a result sits stalled at the output
	assign en = !(m_axis_tvalid && !m_axis_tready);
	assign s_axis_tready = en;
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	assign line_end = ({1'b0, col_q} + 12'd1) >= {1'b0, eff_w};
	assign frame_end = line_end && ({1'b0, row_q} + 13'd1 >= eff_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_xfer) begin
				if (line_end) begin
					col_q <= '0;
					row_q <= frame_end ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + (COL_W+1)'(1);
				end
			end
			if (en) begin
				valid_s1 <= in_xfer;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1 <= s_axis_tdata;
			col_s1 <= col_q[COL_W-1:0];
			tag_s1.row <= row_q - ROW_W'(2);
			tag_s1.col <= col_q[COL_W-1:0] - COL_W'(2);
			tag_s1.last <= frame_end;
			tag_s1.emit <= (row_q >= ROW_W'(4)) && (col_q >= (COL_W+1)'(4));
		end
	end

	// read at accept, write back the shifted column from the s1 stage when the pipe advances
	// a back-to-back same column cannot occur since width is at least five
	assign wr_en_s1 = valid_s1 && en;

	mf5_ram #(.WIDTH(COLUMN_W), .DEPTH(MAX_WIDTH)) u_lines (
		.clk(clk),
		.wr_en(wr_en_s1),
		.wr_addr(col_s1),
		.wr_data({pix_s1, col_data[COLUMN_W-1:PIX_W]}),
		.rd_en(in_xfer),
		.rd_addr(col_q[COL_W-1:0]),
		.rd_data(rd_col)
	);

	// hold read data across a stall since the ram output only follows rd_en
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else begin
			hold_v_q <= !en;
		end
	end
	always_ff @(posedge clk) begin
		hold_q <= col_data;
	end
	assign col_data = hold_v_q ? hold_q : rd_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_SIZE; i++) begin
				win_q[i] <= '0;
			end
			win_valid_q <= 1'b0;
		end else if (en) begin
			win_valid_q <= valid_s1 && tag_s1.emit;
			if (valid_s1) begin
				for (int r = 0; r < WIN_SIDE; r++) begin
					for (int c = 0; c < WIN_SIDE - 1; c++) begin
						win_q[r*WIN_SIDE+c] <= win_q[r*WIN_SIDE+c+1];
					end
				end
				for (int r = 0; r < HIST_LINES; r++) begin
					win_q[r*WIN_SIDE+WIN_SIDE-1] <= col_data[r*PIX_W +: PIX_W];
				end
				win_q[WIN_SIZE-1] <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			win_tag_q <= tag_s1;
		end
	end

	mf5_median u_median (
		.clk(clk), .arst_n(arst_n), .en(en),
		.win(win_q), .in_tag(win_tag_q), .in_valid(win_valid_q),
		.median(med), .out_tag(med_tag), .out_valid(med_valid)
	);

	assign m_axis_tvalid = med_valid;
	assign m_axis_tdata = {2'b00, med_tag.col, med_tag.row, med};
	assign m_axis_tlast = med_tag.last;
endmodule

// ===== tb/median_filter_5x5_top_test.sv =====
`timescale 1ns / 1ps
module median_filter_5x5_top_test;
	import mf5_pkg::*;

	typedef struct {
		logic [7:0] median;
		logic [11:0] row;
		logic [9:0] col;
		logic last;
	} median_result_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	median_filter_5x5_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [7:0] hist_lines [HIST_LINES * MAX_WIDTH];
	logic [7:0] window [WIN_SIZE];
	int col_pos;
	int row_pos;
	int width_reg;
	int height_reg;
	median_result_t pending_medians[$];

	int sender_idle_pct;
	int receiver_stall_pct;
	int hold_off_cycles;
	int mismatches;
	int quiet_cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [7:0] window_median();
		logic [7:0] v [WIN_SIZE];
		logic [7:0] x;
		int j;
		v = window;
		for (int i = 1; i < WIN_SIZE; i++) begin
			x = v[i];
			j = i;
			while (j > 0 && v[j-1] > x) begin
				v[j] = v[j-1];
				j--;
			end
			v[j] = x;
		end
		return v[MEDIAN_RANK];
	endfunction

	function automatic void filter_pixel(logic [7:0] pix);
		int w;
		int h;
		int c;
		bit line_end;
		bit frame_end;
		logic [7:0] column [WIN_SIDE];
		median_result_t r;
		w = width_reg < 5 ? 5 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
		h = height_reg < 5 ? 5 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
		c = col_pos % MAX_WIDTH;
		line_end = col_pos + 1 >= w;
		frame_end = line_end && (row_pos + 1 >= h);
		for (int k = 0; k < HIST_LINES; k++)
			column[k] = hist_lines[k * MAX_WIDTH + c];
		column[HIST_LINES] = pix;
		for (int k = 0; k < HIST_LINES; k++)
			hist_lines[k * MAX_WIDTH + c] = column[k + 1];
		for (int k = 0; k < WIN_SIDE; k++) begin
			for (int m = 0; m < WIN_SIDE - 1; m++)
				window[k * WIN_SIDE + m] = window[k * WIN_SIDE + m + 1];
			window[k * WIN_SIDE + WIN_SIDE - 1] = column[k];
		end
		if (row_pos >= 4 && col_pos >= 4) begin
			r.median = window_median();
			r.row = 12'(row_pos - 2);
			r.col = 10'(col_pos - 2);
			r.last = frame_end;
			pending_medians.push_back(r);
		end
		if (line_end) begin
			col_pos = 0;
			row_pos = frame_end ? 0 : ((row_pos + 1) & 12'hfff);
		end else begin
			col_pos++;
		end
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_pixel(logic [7:0] pix);
		if ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = pix;
		do
			@(posedge clk);
		while (!s_axis_tready);
		filter_pixel(pix);
		@(negedge clk);
	endtask

	function automatic logic [7:0] random_pixel();
		case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (pending_medians.size() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, int value);
		int bits;
		bits = idx == CFG_IDX_WIDTH ? CFG_W_W : CFG_H_W;
		wait_drained();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_DATA_W'(value) | (CFG_DATA_W'($urandom) << bits);
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == CFG_IDX_WIDTH)
			width_reg = value & 12'h7ff;
		else
			height_reg = value & 16'h1fff;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic finish_frame();
		while (col_pos != 0 || row_pos != 0)
			send_pixel(random_pixel());
	endtask

	task automatic test_directed_frame();
		write_reg(CFG_IDX_WIDTH, 5);
		write_reg(CFG_IDX_HEIGHT, 5);
		for (int i = 0; i < 25; i++)
			send_pixel(i % 3 == 0 ? 8'hff : (i % 3 == 1 ? 8'h00 : 8'(i * 37)));
	endtask

	task automatic test_register_extremes();
		// out of range values saturate
		write_reg(CFG_IDX_WIDTH, 0);
		write_reg(CFG_IDX_HEIGHT, 0);
		repeat (25) send_pixel(random_pixel());
		write_reg(CFG_IDX_WIDTH, 5);
		write_reg(CFG_IDX_HEIGHT, 8191);
		repeat (40) send_pixel(random_pixel());
		// height cut below the current row ends the frame at this line
		write_reg(CFG_IDX_HEIGHT, 5);
		finish_frame();
		// oversized width wraps the line at the widest supported line
		write_reg(CFG_IDX_WIDTH, 2047);
		write_reg(CFG_IDX_HEIGHT, 5);
		repeat (1030) send_pixel(random_pixel());
		write_reg(CFG_IDX_WIDTH, 8);
		finish_frame();
	endtask

	task automatic test_width_cut_midframe();
		write_reg(CFG_IDX_WIDTH, 12);
		write_reg(CFG_IDX_HEIGHT, 8);
		repeat (12 * 5 + 9) send_pixel(random_pixel());
		write_reg(CFG_IDX_WIDTH, 6);
		finish_frame();
	endtask

	task automatic test_random_frames(int idle, int stall, int pixels, bit pressure);
		sender_idle_pct = idle;
		receiver_stall_pct = stall;
		for (int sent = 0; sent < pixels; ) begin
			write_reg(CFG_IDX_WIDTH, $urandom_range(5, 30));
			write_reg(CFG_IDX_HEIGHT, $urandom_range(5, 10));
			if (pressure)
				hold_off_cycles = 200;
			do begin
				send_pixel(random_pixel());
				sent++;
				if (pressure && sent % 37 == 0) begin
					s_axis_tvalid = 1'b0;
					while (pending_medians.size() != 0)
						@(negedge clk);
				end
			end while (col_pos != 0 || row_pos != 0);
		end
	endtask

	// receiver ready
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= $urandom_range(99) >= receiver_stall_pct;
		end
	end

	always @(posedge clk) begin
		median_result_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_medians.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: median %0d row %0d col %0d last %0d",
						m_axis_tdata[7:0], m_axis_tdata[19:8], m_axis_tdata[29:20],
						m_axis_tlast);
			end else begin
				e = pending_medians.pop_front();
				if (m_axis_tdata[7:0] !== e.median || m_axis_tdata[19:8] !== e.row
						|| m_axis_tdata[29:20] !== e.col || m_axis_tlast !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
							e.median, e.row, e.col, e.last, m_axis_tdata[7:0],
							m_axis_tdata[19:8], m_axis_tdata[29:20], m_axis_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 20000) begin
			$display("median_filter_5x5_top_test: errors");
			$finish;
		end
	end

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_IDX_WIDTH;
		cfg_data = '0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_off_cycles = 0;
		mismatches = 0;
		quiet_cycles = 0;
		col_pos = 0;
		row_pos = 0;
		width_reg = 640;
		height_reg = 480;
		foreach (hist_lines[i])
			hist_lines[i] = '0;
		foreach (window[i])
			window[i] = '0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_frame();
		test_register_extremes();
		test_width_cut_midframe();
		test_random_frames(0, 0, 80, 1'b0);
		test_random_frames(62, 0, 80, 1'b0);
		test_random_frames(0, 62, 80, 1'b1);
		test_random_frames(38, 38, 80, 1'b0);

		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && pending_medians.size() == 0)
			$display("median_filter_5x5_top_test: clean");
		else
			$display("median_filter_5x5_top_test: errors");
		$finish;
	end
endmodule
